// ===== sv/gmrc_pkg.sv =====
// Package for the Garner mixed-radix conversion block.
// Holds shared widths, defaults and the divider handshake type; no dependencies.
package gmrc_pkg;

    localparam int unsigned MAX_K_DEFAULT = 64;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned RES_W = 64;
    localparam int unsigned POS_W = 6;

    // request to the shared remainder unit
    typedef struct packed {
        logic              start;
        logic [RES_W-1:0]  dividend;
        logic [WORD_W-1:0] divisor;
    } mod_req_t;

endpackage

// ===== sv/gmrc_mod_unit.sv =====
// Shared remainder unit: 64-bit dividend modulo 32-bit divisor, one bit a cycle.
// Depends on gmrc_pkg; divisor must be nonzero.
module gmrc_mod_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gmrc_pkg::mod_req_t        req,
    output logic                      done,
    output logic [gmrc_pkg::WORD_W-1:0] rem
);

    localparam int unsigned CNT_W = $clog2(gmrc_pkg::RES_W + 1);

    logic [gmrc_pkg::RES_W-1:0]  dvd_reg, dvd_next;
    logic [gmrc_pkg::WORD_W-1:0] dvs_reg, dvs_next;
    logic [gmrc_pkg::WORD_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [gmrc_pkg::WORD_W:0]   shifted;

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[gmrc_pkg::WORD_W-1:0], dvd_reg[gmrc_pkg::RES_W-1]};
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            dvd_next = {dvd_reg[gmrc_pkg::RES_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg})
                rem_next = shifted - {1'b0, dvs_reg};
            else
                rem_next = shifted;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(gmrc_pkg::RES_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[gmrc_pkg::WORD_W-1:0];

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("remainder done held");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < {1'b0, dvs_reg}))
        else $error("remainder not reduced");

endmodule

// ===== sv/garner_mixed_radix_conversion_top.sv =====
// Garner mixed-radix conversion, one residue per transaction; uses gmrc_pkg and gmrc_mod_unit.
// Each result passes through bit-serial reductions in the shared remainder unit: one for index 0,
// and for index j > 0 one for the residue, four per stored entry after its RAM read, and a final one;
// overflow and zero-modulus transactions skip the unit; write-back holds while a result waits.
// Throughput: one transaction at a time; the next is accepted the cycle after write-back.
// Reset: asynchronous active low; clears item count and control, not the RAMs.
module garner_mixed_radix_conversion_top
#(
    parameter int unsigned MAX_K = gmrc_pkg::MAX_K_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               first,
    input  logic [gmrc_pkg::RES_W-1:0]         residue,
    input  logic [gmrc_pkg::WORD_W-1:0]        modulus,
    input  logic [gmrc_pkg::WORD_W-1:0]        inverse,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gmrc_pkg::WORD_W-1:0]        coefficient,
    output logic [gmrc_pkg::POS_W-1:0]         position,
    output logic                               overflow
);

    localparam int unsigned IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_K + 1);
    localparam int unsigned W = gmrc_pkg::WORD_W;
    localparam int unsigned RES_W_LOC = gmrc_pkg::RES_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RM    = 9'b000000010,
        S_RD    = 9'b000000100,
        S_AI    = 9'b000001000,
        S_MI    = 9'b000010000,
        S_TERM  = 9'b000100000,
        S_PROD  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_WB    = 9'b100000000
    } state_t;

    logic [W-1:0] coeff_mem [MAX_K];
    logic [W-1:0] mod_mem   [MAX_K];
    logic [W-1:0] coeff_rd_reg, mod_rd_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [W-1:0] m_reg, m_next, inv_reg, inv_next;
    logic [W-1:0] rm_reg, rm_next, sum_reg, sum_next, prod_reg, prod_next;
    logic [W-1:0] ai_reg, ai_next, mi_reg, mi_next;
    logic [W-1:0] a_reg, a_next;
    logic         ovf_item_reg, ovf_item_next;
    logic [1:0]   phase_reg, phase_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] coef_reg, coef_next;
    logic [gmrc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic         ovf_reg, ovf_next;
    logic         we;
    logic [IDX_W-1:0] rd_idx, wr_idx;
    gmrc_pkg::mod_req_t req;
    logic         md_done;
    logic [W-1:0] md_rem;
    logic [W:0]   sum_add;
    logic [W:0]   diff_w;
    logic [W-1:0] diff_sel;

    gmrc_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .done  (md_done),
        .rem   (md_rem)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign rd_idx   = i_reg[IDX_W-1:0];
    assign wr_idx   = j_reg[IDX_W-1:0];
    assign sum_add  = {1'b0, sum_reg} + {1'b0, md_rem};
    assign diff_w   = {1'b0, rm_reg} + {1'b0, m_reg} - {1'b0, sum_reg};
    assign diff_sel = (rm_reg >= sum_reg) ? (rm_reg - sum_reg) : W'(diff_w);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        m_next         = m_reg;
        inv_next       = inv_reg;
        rm_next        = rm_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        ai_next        = ai_reg;
        mi_next        = mi_reg;
        a_next         = a_reg;
        ovf_item_next  = ovf_item_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        coef_next      = coef_reg;
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        we             = 1'b0;
        req.start      = 1'b0;
        req.dividend   = '0;
        req.divisor    = m_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    m_next   = modulus;
                    inv_next = inverse;
                    j_next   = first ? '0 : count_reg;
                    i_next   = '0;
                    sum_next = '0;
                    prod_next = (modulus == W'(1)) ? '0 : W'(1);
                    ovf_item_next = 1'b0;
                    if (!first && count_reg >= CNT_W'(MAX_K))
                    begin
                        // past the end of the set: flag and do not store
                        a_next        = '0;
                        ovf_item_next = 1'b1;
                        state_next    = S_WB;
                    end
                    else if (modulus == '0)
                    begin
                        rm_next    = '0;
                        a_next     = '0;
                        state_next = S_WB;
                    end
                    else
                    begin
                        req.start    = 1'b1;
                        req.dividend = residue;
                        req.divisor  = modulus;
                        state_next   = S_RM;
                    end
                end
            end
            S_RM:
            begin
                if (md_done)
                begin
                    rm_next = md_rem;
                    if (j_reg == '0)
                    begin
                        a_next     = md_rem;
                        state_next = S_WB;
                    end
                    else
                        state_next = S_RD;
                end
            end
            S_RD:
            begin
                // RAM data appears next cycle; then reduce a_i mod m
                state_next = S_AI;
                phase_next = 2'd0;
            end
            S_AI:
            begin
                if (phase_reg == 2'd0)
                begin
                    req.start    = 1'b1;
                    req.dividend = {{(RES_W_LOC-W){1'b0}}, coeff_rd_reg};
                    mi_next      = mod_rd_reg;
                    phase_next   = 2'd1;
                end
                else if (md_done)
                begin
                    ai_next      = md_rem;
                    req.start    = 1'b1;
                    req.dividend = {{(RES_W_LOC-W){1'b0}}, mi_reg};
                    state_next   = S_MI;
                end
            end
            S_MI:
            begin
                if (md_done)
                begin
                    mi_next      = md_rem;
                    req.start    = 1'b1;
                    req.dividend = {{W{1'b0}}, ai_reg} * {{W{1'b0}}, prod_reg};
                    state_next   = S_TERM;
                end
            end
            S_TERM:
            begin
                if (md_done)
                begin
                    sum_next = (sum_add >= {1'b0, m_reg}) ?
                               W'(sum_add - {1'b0, m_reg}) : W'(sum_add);
                    req.start    = 1'b1;
                    req.dividend = {{W{1'b0}}, prod_reg} * {{W{1'b0}}, mi_reg};
                    state_next   = S_PROD;
                end
            end
            S_PROD:
            begin
                if (md_done)
                begin
                    prod_next = md_rem;
                    i_next    = i_reg + 1'b1;
                    if (i_reg + 1'b1 == j_reg)
                    begin
                        req.start    = 1'b1;
                        req.dividend = {{W{1'b0}}, diff_sel} * {{W{1'b0}}, inv_reg};
                        state_next   = S_FIN;
                    end
                    else
                        state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (md_done)
                begin
                    a_next     = md_rem;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // hold until the previous result has left the output register
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    coef_next      = a_reg;
                    ovf_next       = ovf_item_reg;
                    state_next     = S_IDLE;
                    if (ovf_item_reg)
                        pos_next = '0;
                    else
                    begin
                        we         = 1'b1;
                        count_next = j_reg + 1'b1;
                        pos_next   = gmrc_pkg::POS_W'(j_reg);
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (state_reg == S_IDLE && in_valid && in_ready && first)
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        i_reg        <= i_next;
        m_reg        <= m_next;
        inv_reg      <= inv_next;
        rm_reg       <= rm_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        ai_reg       <= ai_next;
        mi_reg       <= mi_next;
        a_reg        <= a_next;
        ovf_item_reg <= ovf_item_next;
        coef_reg     <= coef_next;
        pos_reg      <= pos_next;
        ovf_reg      <= ovf_next;
    end

    // store RAMs: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            coeff_mem[wr_idx] <= a_reg;
            mod_mem[wr_idx]   <= m_reg;
        end
        coeff_rd_reg <= coeff_mem[rd_idx];
        mod_rd_reg   <= mod_mem[rd_idx];
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coef_reg;
    assign position    = pos_reg;
    assign overflow    = ovf_reg;

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_reg) |-> (coef_reg == '0))
        else $error("overflow with nonzero coefficient");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_K))
        else $error("item count past limit");
    a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |=> out_valid_reg)
        else $error("write-back without result");
    a_read_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (i_reg < j_reg))
        else $error("read beyond stored entries");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for garner_mixed_radix_conversion_top: directed, overflow and random sets.
// Depends on gmrc_pkg and the top module; predicts each coefficient in-bench.
module tb;

    localparam int unsigned SET_MAX = gmrc_pkg::MAX_K_DEFAULT;
    localparam int unsigned WORD_W  = gmrc_pkg::WORD_W;
    localparam int unsigned RES_W   = gmrc_pkg::RES_W;
    localparam int unsigned POS_W   = gmrc_pkg::POS_W;

    typedef struct {
        logic [WORD_W-1:0] coeff;
        logic [POS_W-1:0]  pos;
        logic              ovf;
    } garner_digit_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              first;
    logic [RES_W-1:0]  residue;
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] inverse;
    logic              out_valid;
    logic              out_ready;
    logic [WORD_W-1:0] coefficient;
    logic [POS_W-1:0]  position;
    logic              overflow;

    garner_digit_t pending_digits[$];
    logic [WORD_W-1:0] coeff_hist[SET_MAX];
    logic [WORD_W-1:0] mod_hist[SET_MAX];
    int unsigned set_len;
    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned fail_count;

    garner_mixed_radix_conversion_top #(.MAX_K(SET_MAX)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first(first), .residue(residue), .modulus(modulus), .inverse(inverse),
        .out_valid(out_valid), .out_ready(out_ready),
        .coefficient(coefficient), .position(position), .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        return ((x & 64'hFFFF_FFFF) * (y & 64'hFFFF_FFFF)) % m;
    endfunction

    // Advance the set state and return the coefficient this transaction should produce.
    function automatic garner_digit_t garner_digit(logic f, logic [RES_W-1:0] r,
                                                   logic [WORD_W-1:0] m, logic [WORD_W-1:0] inv);
        garner_digit_t d;
        logic [63:0] m64, acc, prod, rm, diff, a;
        int unsigned j;
        if (f)
            set_len = 0;
        j = set_len;
        if (j >= SET_MAX)
        begin
            d.coeff = '0;
            d.pos   = '0;
            d.ovf   = 1'b1;
            return d;
        end
        m64 = {32'd0, m};
        a = 0;
        if (m64 != 0)
        begin
            acc  = 0;
            prod = 1 % m64;
            rm   = r % m64;
            for (int i = 0; i < j; i++)
            begin
                acc  = (acc + mulmod({32'd0, coeff_hist[i]} % m64, prod, m64)) % m64;
                prod = mulmod(prod, {32'd0, mod_hist[i]} % m64, m64);
            end
            if (j == 0)
                a = rm;
            else
            begin
                diff = (rm >= acc) ? (rm - acc) : (rm + m64 - acc);
                a = mulmod(diff, {32'd0, inv}, m64);
            end
        end
        coeff_hist[j] = a[31:0];
        mod_hist[j]   = m;
        set_len = j + 1;
        d.coeff = a[31:0];
        d.pos   = j[POS_W-1:0];
        d.ovf   = 1'b0;
        return d;
    endfunction

    // Caller is at a falling edge; hold the item until accepted, then maybe idle.
    task automatic send_item(logic f, logic [RES_W-1:0] r, logic [WORD_W-1:0] m,
                             logic [WORD_W-1:0] inv);
        first    = f;
        residue  = r;
        modulus  = m;
        inverse  = inv;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_digits.insert(pending_digits.size(), garner_digit(f, r, m, inv));
        items_sent++;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 60);
        end
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_digits.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_modulus();
        case ($urandom_range(19))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'hFFFF_FFFF;
            4: return 32'hFFFF_FFFB;
            5: return $urandom_range(255, 2);
            default: return $urandom_range(32'hFFFF_FFFF, 2);
        endcase
    endfunction

    function automatic logic [RES_W-1:0] pick_residue();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed_edges();
        // continuation with no start right after reset acts as index zero
        send_item(1'b0, 64'd12345, 32'd7, 32'd3);
        send_item(1'b0, 64'd10, 32'd11, 32'd2);
        // small prime set
        send_item(1'b1, 64'd2, 32'd3, 32'd0);
        send_item(1'b0, 64'd3, 32'd5, 32'd2);
        send_item(1'b0, 64'd2, 32'd7, 32'd1);
        // extreme residues and moduli, inverse not reduced
        send_item(1'b1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, '1, 32'hFFFF_FFFB, 32'hFFFF_FFFF);
        send_item(1'b0, '0, 32'd2, 32'hFFFF_FFFF);
        send_item(1'b0, 64'hAAAA_5555_AAAA_5555, 32'h8000_0001, 32'h0);
        // zero and one moduli, stored then read by later items
        send_item(1'b1, 64'd99, 32'd0, 32'd5);
        send_item(1'b0, 64'd99, 32'd13, 32'd7);
        send_item(1'b0, 64'd99, 32'd1, 32'd7);
        send_item(1'b0, 64'h5555_AAAA_5555_AAAA, 32'd17, 32'd40);
        send_item(1'b1, 64'd0, 32'd1, 32'd0);
        send_item(1'b1, 64'd1, 32'd2, 32'd1);
        drain_results();
    endtask

    task automatic test_overflow_set();
        send_item(1'b1, pick_residue(), pick_modulus(), $urandom);
        for (int k = 1; k < SET_MAX + 3; k++)
            send_item(1'b0, pick_residue(), $urandom_range(32'hFFFF_FFFF, 2), $urandom);
        // a fresh start must clear the overflowed set
        send_item(1'b1, pick_residue(), pick_modulus(), $urandom);
        send_item(1'b0, pick_residue(), pick_modulus(), $urandom);
        drain_results();
    endtask

    task automatic test_random_sets(int unsigned target);
        int unsigned len, stop_at, span;
        stop_at = items_sent + target;
        span = target / 3;
        while (items_sent < stop_at)
        begin
            if (items_sent < stop_at - 2 * span)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 74;
            end
            else if (items_sent < stop_at - span)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(19))
                0, 1: len = $urandom_range(12, 5);
                2:    len = 0;
                default: len = $urandom_range(4, 1);
            endcase
            if (len == 0)
                // stray continuation extends whatever set is open
                send_item(1'b0, pick_residue(), pick_modulus(), $urandom);
            else
                for (int k = 0; k < len; k++)
                    send_item(k == 0, pick_residue(), pick_modulus(), $urandom);
            if ($urandom_range(49) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Drive out_ready at falling edges; check each accepted result at rising edges.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        garner_digit_t exp_d;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected result: coefficient %0d position %0d overflow %0b",
                       coefficient, position, overflow);
                fail_count++;
            end
            else
            begin
                exp_d = pending_digits.pop_front();
                if (coefficient !== exp_d.coeff)
                begin
                    $error("coefficient: expected %0d, actual %0d", exp_d.coeff, coefficient);
                    fail_count++;
                end
                if (position !== exp_d.pos)
                begin
                    $error("position: expected %0d, actual %0d", exp_d.pos, position);
                    fail_count++;
                end
                if (overflow !== exp_d.ovf)
                begin
                    $error("overflow: expected %0b, actual %0b", exp_d.ovf, overflow);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        first = 1'b0;
        residue = '0;
        modulus = '0;
        inverse = '0;
        set_len = 0;
        items_sent = 0;
        fail_count = 0;
        send_idle_pct = 11;
        recv_idle_pct = 74;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_overflow_set();
        test_random_sets(1060);

        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_digits.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
